### rtl/vbf_pkg.sv
`timescale 1ns / 1ps
package vbf_pkg;

  localparam int QW = 32;   // Q16.16 word
  localparam int SW = 31;   // size field width
  localparam int DW = 47;   // dividend width (size << 16)
  localparam int NSTG = 47; // divider stages, one quotient bit each

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;

  localparam logic [3:0] ALIGN_UNKNOWN = 4'd0;
  localparam logic [3:0] ALIGN_NONE    = 4'd1;
  localparam logic [3:0] ALIGN_LAST    = 4'd10;

  localparam logic [1:0] FIT_MEET  = 2'd1;
  localparam logic [1:0] FIT_SLICE = 2'd2;

  localparam logic [1:0] SEL_MIN = 2'd0;
  localparam logic [1:0] SEL_MID = 2'd1;
  localparam logic [1:0] SEL_MAX = 2'd2;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // per-item control travelling down the pipe
  typedef struct packed {
    logic [1:0] status;
    logic       none_mode;
    logic       by_height;
    logic [1:0] xsel;
    logic [1:0] ysel;
  } ctl_t;

  // data that rides along with the dividers
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [SW-1:0]      vw;
    logic [SW-1:0]      vh;
    logic [SW-1:0]      pw;
    logic [SW-1:0]      ph;
    ctl_t               ctl;
  } side_t;

endpackage

### rtl/vbf_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage; quotient saturated to 32 bits.
module vbf_div
  import vbf_pkg::*;
(
  input  logic                 clk,
  input  logic                 adv,
  input  logic [SW-1:0]        num,
  input  logic [SW-1:0]        den,
  output logic [QW-1:0]        quo
);

  logic [DW-1:0] n_r [NSTG+1];
  logic [SW:0]   r_r [NSTG+1];
  logic [SW-1:0] d_r [NSTG+1];

  assign n_r[0] = {num, 16'h0};
  assign r_r[0] = '0;
  assign d_r[0] = den;

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    logic [SW+1:0] trial;
    logic          ge;
    logic [SW:0]   rem;
    logic [DW-1:0] q_r;
    logic [SW:0]   rr_r;
    logic [SW-1:0] dd_r;
    always_comb begin
      trial = {r_r[i], n_r[i][DW-1]};
      ge    = trial >= {2'b00, d_r[i]};
      rem   = ge ? 32'(trial - {2'b00, d_r[i]}) : trial[SW:0];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        q_r  <= {n_r[i][DW-2:0], ge};
        rr_r <= rem;
        dd_r <= d_r[i];
      end
    end
    assign n_r[i+1] = q_r;
    assign r_r[i+1] = rr_r;
    assign d_r[i+1] = dd_r;
  end

  assign quo = (|n_r[NSTG][DW-1:QW]) ? '1 : n_r[NSTG][QW-1:0];

endmodule

### rtl/vbf_delay.sv
`timescale 1ns / 1ps
// Side-data delay line matching the divider depth.
module vbf_delay
  import vbf_pkg::*;
(
  input  logic  clk,
  input  logic  adv,
  input  side_t din,
  output side_t dout
);

  side_t sh_r [NSTG];

  always_ff @(posedge clk) begin
    if (adv) begin
      sh_r[0] <= din;
      for (int i = 1; i < NSTG; i++) sh_r[i] <= sh_r[i-1];
    end
  end

  assign dout = sh_r[NSTG-1];

endmodule

### rtl/viewbox_fit_transform.sv
`timescale 1ns / 1ps
// Pipeline: 1 decode stage, 47 divider stages and 5 multiply / shift
//   stages lie between input request and result.
// Throughput: one request per cycle; the whole pipe advances unless the
//   output register is full and stalled.
// Reset: rst_n synchronous active low; clears valid bits and both
//   configuration registers (align unknown, fit unknown).
module viewbox_fit_transform
  import vbf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [3:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_view_x,
  input  logic signed [31:0]   in_view_y,
  input  logic [30:0]          in_view_width,
  input  logic [30:0]          in_view_height,
  input  logic [30:0]          in_port_width,
  input  logic [30:0]          in_port_height,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_scale_x,
  output logic [31:0]          out_scale_y,
  output logic signed [31:0]   out_shift_x,
  output logic signed [31:0]   out_shift_y,
  output logic [1:0]           out_status
);

  localparam int NV = NSTG + 6; // valid bits: decode, divider, back end

  logic [3:0] align_r;
  logic [1:0] fit_r;
  logic [NV-1:0] v_r;
  logic adv;

  // The pipe moves as a whole; it only halts when the last stage holds a
  // result the consumer stalls.
  assign adv      = !(v_r[NV-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r <= ALIGN_UNKNOWN;
      fit_r   <= 2'd0;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) align_r <= cfg_data;
      else                    fit_r   <= cfg_data[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[NV-2:0], in_valid};
  end

  // ---- stage 0: decode and exact aspect compare (31x31 multiplies) ----
  side_t s0_r;
  logic [61:0] p_vwph, p_pwvh;
  ctl_t c0;
  logic [3:0] a0;
  logic narrower;
  always_comb begin
    p_vwph   = in_view_width * in_port_height;
    p_pwvh   = in_port_width * in_view_height;
    narrower = p_vwph < p_pwvh;
    a0       = align_r - 4'd2;
    c0.none_mode = align_r == ALIGN_NONE;
    c0.by_height = (narrower && fit_r == FIT_MEET) ||
                   (!narrower && fit_r == FIT_SLICE);
    c0.xsel = (a0 >= 4'd6) ? 2'(a0 - 4'd6) : (a0 >= 4'd3) ? 2'(a0 - 4'd3) : a0[1:0];
    c0.ysel = (a0 >= 4'd6) ? SEL_MAX : (a0 >= 4'd3) ? SEL_MID : SEL_MIN;
    if (align_r == ALIGN_UNKNOWN || align_r > ALIGN_LAST) c0.status = ST_UNKNOWN;
    else if (in_view_width == '0 || in_view_height == '0 ||
             in_port_width == '0 || in_port_height == '0) c0.status = ST_ZERO;
    else c0.status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r.vx  <= in_view_x;
      s0_r.vy  <= in_view_y;
      s0_r.vw  <= in_view_width;
      s0_r.vh  <= in_view_height;
      s0_r.pw  <= in_port_width;
      s0_r.ph  <= in_port_height;
      s0_r.ctl <= c0;
    end
  end

  // ---- divider pipes: width scale and height scale ----
  logic [31:0] qx, qy;
  side_t s1;
  // zero divisors would be flagged anyway; feed 1 to keep values defined
  vbf_div u_divx (.clk, .adv, .num(s0_r.pw),
                  .den(s0_r.vw == '0 ? 31'd1 : s0_r.vw), .quo(qx));
  vbf_div u_divy (.clk, .adv, .num(s0_r.ph),
                  .den(s0_r.vh == '0 ? 31'd1 : s0_r.vh), .quo(qy));
  vbf_delay u_dly (.clk, .adv, .din(s0_r), .dout(s1));

  // ---- stage A: choose scales ----
  logic [31:0] sxa_r, sya_r;
  side_t sa_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sa_r <= s1;
      if (s1.ctl.none_mode) begin
        sxa_r <= qx; sya_r <= qy;
      end else begin
        sxa_r <= s1.ctl.by_height ? qy : qx;
        sya_r <= s1.ctl.by_height ? qy : qx;
      end
    end
  end

  // ---- stage B: multiplies s*pos and s*len (33 x 32 signed) ----
  logic signed [64:0] mpx_r, mpy_r, mlen_r;
  logic [31:0] sxb_r, syb_r;
  logic [30:0] portl_b_r;
  ctl_t cb_r;
  logic [30:0] lensel;
  always_comb lensel = sa_r.ctl.by_height ? sa_r.vw : sa_r.vh;
  always_ff @(posedge clk) begin
    if (adv) begin
      mpx_r  <= $signed({1'b0, sxa_r}) * sa_r.vx;
      mpy_r  <= $signed({1'b0, sya_r}) * sa_r.vy;
      mlen_r <= $signed({1'b0, sxa_r}) * $signed({1'b0, lensel});
      portl_b_r <= sa_r.ctl.by_height ? sa_r.pw : sa_r.ph;
      sxb_r <= sxa_r; syb_r <= sya_r;
      cb_r  <= sa_r.ctl;
    end
  end

  // ---- stage C: floor shift, slack term ----
  logic signed [49:0] bx_r, by_r, w_r;
  logic [31:0] sxc_r, syc_r;
  ctl_t cc_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      bx_r <= -(50'(mpx_r >>> 16));
      by_r <= -(50'(mpy_r >>> 16));
      w_r  <= 50'(mlen_r >>> 16) - $signed({19'd0, portl_b_r});
      sxc_r <= sxb_r; syc_r <= syb_r;
      cc_r  <= cb_r;
    end
  end

  // ---- stage D: apply alignment ----
  logic signed [50:0] tx_r, ty_r;
  logic [31:0] sxd_r, syd_r;
  ctl_t cd_r;
  logic signed [50:0] adj;
  logic [1:0] sel;
  always_comb begin
    sel = cc_r.by_height ? cc_r.xsel : cc_r.ysel;
    if (cc_r.none_mode || sel == SEL_MIN) adj = '0;
    else if (sel == SEL_MID) adj = 51'(w_r >>> 1);
    else adj = 51'(w_r);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      tx_r <= 51'(bx_r) - ((cc_r.by_height && !cc_r.none_mode) ? adj : 51'sd0);
      ty_r <= 51'(by_r) - ((!cc_r.by_height && !cc_r.none_mode) ? adj : 51'sd0);
      sxd_r <= sxc_r; syd_r <= syc_r;
      cd_r  <= cc_r;
    end
  end

  // ---- stage E: saturate, identity cases, output register ----
  function automatic logic [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647)       return 32'h7FFF_FFFF;
    else if (v < -51'sd2147483648) return 32'h8000_0000;
    else return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status <= cd_r.status;
      if (cd_r.status != ST_OK) begin
        out_scale_x <= ONE_Q16; out_scale_y <= ONE_Q16;
        out_shift_x <= '0;      out_shift_y <= '0;
      end else begin
        out_scale_x <= sxd_r; out_scale_y <= syd_r;
        out_shift_x <= sat32(tx_r);
        out_shift_y <= sat32(ty_r);
      end
    end
  end

  assign out_valid = v_r[NV-1];

endmodule

### rtl/vbf_checker.sv
`timescale 1ns / 1ps
module vbf_checker
  import vbf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_scale_x,
  input logic [31:0] out_scale_y,
  input logic [1:0]  out_status
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_scale_x))
    else $error("stalled result changed");

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("bad status");

  a_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_scale_x == ONE_Q16 &&
    out_scale_y == ONE_Q16)
    else $error("identity scale wrong");

endmodule

bind viewbox_fit_transform vbf_checker u_vbf_checker (.*);
